@@ hw/rtl/bdad_pkg.sv @@
// Shared types, constants and codes of the button debounce and action decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package bdad_pkg;

    localparam int BUTTON_COUNT_DEF = 4;
    localparam int TIME_BITS_DEF    = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam int MASK_W      = 4;
    localparam int FIRED_W     = 8;
    localparam int LEN_W       = 10;
    localparam int BRIGHT_W    = 2;
    localparam int WINDOW_W    = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [LEN_W-1:0]    LEN_MAX             = 10'd1023;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET        = 16'd200;
    localparam logic [LEN_W-1:0]    LONG_PRESET_RESET   = 10'd10;
    localparam logic [LEN_W-1:0]    SHORT_PRESET_RESET  = 10'd5;
    localparam logic [BRIGHT_W-1:0] BRIGHT_TOP_RESET    = 2'd2;

    // Button roles by bit position
    localparam int BTN_LONG   = 0;
    localparam int BTN_SHORT  = 1;
    localparam int BTN_INC    = 2;
    localparam int BTN_BRIGHT = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_WINDOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESET     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_PRESET    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS_TOP  = 2'd3;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_MULTI,
        ACT_LONG,
        ACT_SHORT,
        ACT_INC,
        ACT_BRIGHT
    } t_action;

    typedef struct packed {
        logic [WINDOW_W-1:0] debounce_window;
        logic [LEN_W-1:0]    long_preset;
        logic [LEN_W-1:0]    short_preset;
        logic [BRIGHT_W-1:0] brightness_top;
    } t_cfg;

    typedef struct packed {
        logic [MASK_W-1:0]   pressed;
        t_action             action;
        logic [LEN_W-1:0]    len;
        logic [BRIGHT_W-1:0] bright;
        logic                running;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

@@ hw/rtl/bdad_front.sv @@
// Front end: accepts button samples, runs edge detection and lockout per button,
// and classifies each sample into an action record. Depends on bdad_pkg.
module bdad_front #(
    parameter int BUTTON_COUNT = bdad_pkg::BUTTON_COUNT_DEF,
    parameter int TIME_BITS    = bdad_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [BUTTON_COUNT-1:0]         i_button_levels,
    input  logic [TIME_BITS-1:0]            i_now_ms,
    input  logic [bdad_pkg::LEN_W-1:0]      i_timer_length_in,
    input  logic [bdad_pkg::BRIGHT_W-1:0]   i_brightness_in,
    input  logic                            i_timer_running,
    input  logic [bdad_pkg::WINDOW_W-1:0]   i_debounce_window,
    input  bdad_pkg::t_queue_status         i_queue_status,
    output logic                            o_push,
    output bdad_pkg::t_item                 o_item
);

    logic [BUTTON_COUNT-1:0] r_prev_levels;
    logic [BUTTON_COUNT-1:0] n_prev_levels;
    logic [TIME_BITS-1:0]    r_last_time [BUTTON_COUNT];
    logic [TIME_BITS-1:0]    n_last_time [BUTTON_COUNT];
    logic [TIME_BITS-1:0]    elapsed     [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] fired;
    logic [bdad_pkg::FIRED_W-1:0] fired_ext;
    logic                    multi;

    assign o_in_stall = i_queue_status.full;
    assign o_push     = i_in_valid && !i_queue_status.full;

    always_comb begin
        fired         = '0;
        n_prev_levels = i_button_levels;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            n_last_time[i] = r_last_time[i];
            elapsed[i]     = i_now_ms - r_last_time[i];
            if (!i_button_levels[i] && r_prev_levels[i]) begin
                if (elapsed[i] >= TIME_BITS'(i_debounce_window)) begin
                    fired[i]       = 1'b1;
                    n_last_time[i] = i_now_ms;
                end
            end
        end
    end

    always_comb begin
        fired_ext                   = '0;
        fired_ext[BUTTON_COUNT-1:0] = fired;
        multi                       = |(fired_ext & (fired_ext - 1'b1));
    end

    always_comb begin
        o_item.pressed = fired_ext[bdad_pkg::MASK_W-1:0];
        o_item.len     = i_timer_length_in;
        o_item.bright  = i_brightness_in;
        o_item.running = i_timer_running;
        if (multi) begin
            o_item.action = bdad_pkg::ACT_MULTI;
        end else if (fired_ext[bdad_pkg::BTN_LONG]) begin
            o_item.action = bdad_pkg::ACT_LONG;
        end else if (fired_ext[bdad_pkg::BTN_SHORT]) begin
            o_item.action = bdad_pkg::ACT_SHORT;
        end else if (fired_ext[bdad_pkg::BTN_INC]) begin
            o_item.action = bdad_pkg::ACT_INC;
        end else if (fired_ext[bdad_pkg::BTN_BRIGHT]) begin
            o_item.action = bdad_pkg::ACT_BRIGHT;
        end else begin
            o_item.action = bdad_pkg::ACT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_levels <= '1;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_last_time[i] <= '0;
            end
        end else if (o_push) begin
            r_prev_levels <= n_prev_levels;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_last_time[i] <= n_last_time[i];
            end
        end
    end

    a_lockout_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && fired[0]) |=> (r_last_time[0] == $past(i_now_ms)))
        else $error("fired button did not record its press time");

    a_multi_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && ($countones(fired) > 1)) |-> (o_item.action == bdad_pkg::ACT_MULTI))
        else $error("several fired buttons not flagged as multi-press");

    a_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_push |=> $stable(r_prev_levels))
        else $error("level history moved without an accepted sample");

endmodule

@@ hw/rtl/bdad_queue.sv @@
// Short register queue between the front and back ends of the decoder.
// Generic over entry width and depth; depends on bdad_pkg for the status type.
module bdad_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = bdad_pkg::QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [WIDTH-1:0]        i_wr_data,
    input  logic                    i_pop,
    output logic [WIDTH-1:0]        o_rd_data,
    output bdad_pkg::t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_rd_data      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.empty || o_status.full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> !o_status.empty)
        else $error("queue empty after a lone push");

endmodule

@@ hw/rtl/bdad_back.sv @@
// Back end: applies the classified action of each queued sample and holds the
// result in an output register. Depends on bdad_pkg.
module bdad_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bdad_pkg::t_cfg                i_cfg,
    input  bdad_pkg::t_item               i_item,
    input  bdad_pkg::t_queue_status       i_queue_status,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bdad_pkg::MASK_W-1:0]   o_pressed_mask,
    output logic                          o_multi_press,
    output logic [bdad_pkg::LEN_W-1:0]    o_timer_length_out,
    output logic [bdad_pkg::BRIGHT_W-1:0] o_brightness_out,
    output logic                          o_brightness_changed
);

    logic                          r_valid;
    logic [bdad_pkg::MASK_W-1:0]   r_pressed;
    logic                          r_multi;
    logic [bdad_pkg::LEN_W-1:0]    r_len;
    logic [bdad_pkg::BRIGHT_W-1:0] r_bright;
    logic                          r_changed;
    logic                          n_multi;
    logic [bdad_pkg::LEN_W-1:0]    n_len;
    logic [bdad_pkg::BRIGHT_W-1:0] n_bright;
    logic                          n_changed;

    // Take the next entry whenever the output register is free or draining
    assign o_pop = !i_queue_status.empty && (!r_valid || !i_out_stall);

    always_comb begin
        n_multi   = 1'b0;
        n_len     = i_item.len;
        n_bright  = i_item.bright;
        n_changed = 1'b0;
        unique case (i_item.action)
            bdad_pkg::ACT_NONE: begin
            end
            bdad_pkg::ACT_MULTI: begin
                n_multi = 1'b1;
            end
            bdad_pkg::ACT_LONG: begin
                if (!i_item.running) n_len = i_cfg.long_preset;
            end
            bdad_pkg::ACT_SHORT: begin
                if (!i_item.running) n_len = i_cfg.short_preset;
            end
            bdad_pkg::ACT_INC: begin
                if (i_item.len != bdad_pkg::LEN_MAX) n_len = i_item.len + 1'b1;
            end
            bdad_pkg::ACT_BRIGHT: begin
                n_bright  = (i_item.bright >= i_cfg.brightness_top) ? '0
                                                                    : i_item.bright + 1'b1;
                n_changed = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pressed <= i_item.pressed;
            r_multi   <= n_multi;
            r_len     <= n_len;
            r_bright  <= n_bright;
            r_changed <= n_changed;
        end
    end

    assign o_out_valid          = r_valid;
    assign o_pressed_mask       = r_pressed;
    assign o_multi_press        = r_multi;
    assign o_timer_length_out   = r_len;
    assign o_brightness_out     = r_bright;
    assign o_brightness_changed = r_changed;

    a_changed_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_changed) |-> (!r_multi && r_pressed[bdad_pkg::BTN_BRIGHT]
                                    && ($countones(r_pressed) == 1)))
        else $error("brightness strobe without a lone button-four press");

    a_multi_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_multi) |-> !r_changed)
        else $error("multi-press took an action");

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped entry did not reach the output register");

endmodule

@@ hw/rtl/button_debounce_action_decoder.sv @@
// An accepted sample is written into the queue; from there it is loaded into the
// output register once that register is free or draining, and the output register
// holds the result beat, also a stalled one, until the receiver takes it.
// Throughput: one sample per cycle unless the queue is full; the two-entry queue
// lets the front keep accepting while the back holds a stalled result.
// Reset (synchronous, active low): all buttons released, press times zero,
// queue empty, output invalid, configuration registers at their defaults.
module button_debounce_action_decoder #(
    parameter int BUTTON_COUNT = bdad_pkg::BUTTON_COUNT_DEF,
    parameter int TIME_BITS    = bdad_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [BUTTON_COUNT-1:0]            i_button_levels,
    input  logic [TIME_BITS-1:0]               i_now_ms,
    input  logic [bdad_pkg::LEN_W-1:0]         i_timer_length_in,
    input  logic [bdad_pkg::BRIGHT_W-1:0]      i_brightness_in,
    input  logic                               i_timer_running,
    // Result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [bdad_pkg::MASK_W-1:0]        o_pressed_mask,
    output logic                               o_multi_press,
    output logic [bdad_pkg::LEN_W-1:0]         o_timer_length_out,
    output logic [bdad_pkg::BRIGHT_W-1:0]      o_brightness_out,
    output logic                               o_brightness_changed,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bdad_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bdad_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int ITEM_W = $bits(bdad_pkg::t_item);

    bdad_pkg::t_cfg          r_cfg;
    bdad_pkg::t_item         front_item;
    bdad_pkg::t_item         queue_item;
    bdad_pkg::t_queue_status queue_status;
    logic                    push;
    logic                    pop;
    logic [ITEM_W-1:0]       queue_rd_data;

    // Configuration registers: always ready, one register per write beat
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_window <= bdad_pkg::WINDOW_RESET;
            r_cfg.long_preset     <= bdad_pkg::LONG_PRESET_RESET;
            r_cfg.short_preset    <= bdad_pkg::SHORT_PRESET_RESET;
            r_cfg.brightness_top  <= bdad_pkg::BRIGHT_TOP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bdad_pkg::CFG_DEBOUNCE_WINDOW: begin
                    r_cfg.debounce_window <= i_cfg_data[bdad_pkg::WINDOW_W-1:0];
                end
                bdad_pkg::CFG_LONG_PRESET: begin
                    r_cfg.long_preset <= i_cfg_data[bdad_pkg::LEN_W-1:0];
                end
                bdad_pkg::CFG_SHORT_PRESET: begin
                    r_cfg.short_preset <= i_cfg_data[bdad_pkg::LEN_W-1:0];
                end
                bdad_pkg::CFG_BRIGHTNESS_TOP: begin
                    r_cfg.brightness_top <= i_cfg_data[bdad_pkg::BRIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front: edge detect, lockout against the debounce window, classify
    bdad_front #(
        .BUTTON_COUNT (BUTTON_COUNT),
        .TIME_BITS    (TIME_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_button_levels   (i_button_levels),
        .i_now_ms          (i_now_ms),
        .i_timer_length_in (i_timer_length_in),
        .i_brightness_in   (i_brightness_in),
        .i_timer_running   (i_timer_running),
        .i_debounce_window (r_cfg.debounce_window),
        .i_queue_status    (queue_status),
        .o_push            (push),
        .o_item            (front_item)
    );

    // Queue: decouple front acceptance from back-end stalls
    bdad_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (bdad_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (front_item),
        .i_pop     (pop),
        .o_rd_data (queue_rd_data),
        .o_status  (queue_status)
    );

    assign queue_item = bdad_pkg::t_item'(queue_rd_data);

    // Back: apply the action and hold the result beat
    bdad_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_item               (queue_item),
        .i_queue_status       (queue_status),
        .o_pop                (pop),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_pressed_mask       (o_pressed_mask),
        .o_multi_press        (o_multi_press),
        .o_timer_length_out   (o_timer_length_out),
        .o_brightness_out     (o_brightness_out),
        .o_brightness_changed (o_brightness_changed)
    );

endmodule

@@ tb/tb_button_debounce_action_decoder.sv @@
// Self-checking bench for button_debounce_action_decoder: drives button samples
// and register writes, predicts every result beat and compares it field by field.
// Depends on bdad_pkg and the block's RTL only.
module tb_button_debounce_action_decoder;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PRINT_LIMIT   = 60;
    localparam int PHASE_ITEMS   = 500;

    localparam int MASK_W      = bdad_pkg::MASK_W;
    localparam int LEN_W       = bdad_pkg::LEN_W;
    localparam int BRIGHT_W    = bdad_pkg::BRIGHT_W;
    localparam int WINDOW_W    = bdad_pkg::WINDOW_W;
    localparam int CFG_INDEX_W = bdad_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = bdad_pkg::CFG_DATA_W;

    // All four buttons released (active low)
    localparam logic [MASK_W-1:0] RELEASED = '1;

    // One result beat as the panel sees it
    typedef struct packed {
        logic [MASK_W-1:0]   pressed;
        logic                multi;
        logic [LEN_W-1:0]    len;
        logic [BRIGHT_W-1:0] bright;
        logic                changed;
    } t_panel_update;

    logic                   i_clk                = 1'b0;
    logic                   i_rst_n              = 1'b0;
    logic                   i_in_valid           = 1'b0;
    logic                   o_in_stall;
    logic [MASK_W-1:0]      i_button_levels      = '1;
    logic [31:0]            i_now_ms             = '0;
    logic [LEN_W-1:0]       i_timer_length_in    = '0;
    logic [BRIGHT_W-1:0]    i_brightness_in      = '0;
    logic                   i_timer_running      = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall          = 1'b0;
    logic [MASK_W-1:0]      o_pressed_mask;
    logic                   o_multi_press;
    logic [LEN_W-1:0]       o_timer_length_out;
    logic [BRIGHT_W-1:0]    o_brightness_out;
    logic                   o_brightness_changed;
    logic                   i_cfg_valid          = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index          = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data           = '0;

    button_debounce_action_decoder u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_button_levels      (i_button_levels),
        .i_now_ms             (i_now_ms),
        .i_timer_length_in    (i_timer_length_in),
        .i_brightness_in      (i_brightness_in),
        .i_timer_running      (i_timer_running),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_pressed_mask       (o_pressed_mask),
        .o_multi_press        (o_multi_press),
        .o_timer_length_out   (o_timer_length_out),
        .o_brightness_out     (o_brightness_out),
        .o_brightness_changed (o_brightness_changed),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Predictor state: our own copy of the registers and the debounce memory
    logic [WINDOW_W-1:0] window_ms;
    logic [LEN_W-1:0]    long_len;
    logic [LEN_W-1:0]    short_len;
    logic [BRIGHT_W-1:0] bright_top;
    logic [MASK_W-1:0]   held_level;
    logic [31:0]         press_stamp [MASK_W];

    t_panel_update expected_updates [$];
    int            mismatch_count = 0;

    // Idle percentages of the sample sender and the result receiver
    int gap_pct   = 0;
    int stall_pct = 0;

    // Report one failing observation; stop printing after a while but keep counting
    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("ERROR t=%0t %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Level pattern with one button held down
    function automatic logic [MASK_W-1:0] press_of(int btn);
        return ~(MASK_W'(1) << btn);
    endfunction

    // Work out the panel update for one sample and advance the debounce memory
    function automatic t_panel_update decode_panel_sample(
        logic [MASK_W-1:0] levels, logic [31:0] now, logic [LEN_W-1:0] len,
        logic [BRIGHT_W-1:0] bright, logic running);
        t_panel_update upd;
        logic [MASK_W-1:0] fired;
        logic [31:0] elapsed;
        int b;
        fired = '0;
        for (b = 0; b < MASK_W; b++) begin
            // Fire on a falling edge only once the lockout window has run out
            if (!levels[b] && held_level[b]) begin
                elapsed = now - press_stamp[b];
                if (elapsed >= {16'b0, window_ms}) begin
                    fired[b]       = 1'b1;
                    press_stamp[b] = now;
                end
            end
            held_level[b] = levels[b];
        end
        upd.pressed = fired;
        upd.multi   = 1'b0;
        upd.len     = len;
        upd.bright  = bright;
        upd.changed = 1'b0;
        if ($countones(fired) > 1) begin
            upd.multi = 1'b1;
        end else if (fired == (MASK_W'(1) << bdad_pkg::BTN_LONG)) begin
            if (!running) upd.len = long_len;
        end else if (fired == (MASK_W'(1) << bdad_pkg::BTN_SHORT)) begin
            if (!running) upd.len = short_len;
        end else if (fired == (MASK_W'(1) << bdad_pkg::BTN_INC)) begin
            if (len != bdad_pkg::LEN_MAX) upd.len = len + 1'b1;
        end else if (fired == (MASK_W'(1) << bdad_pkg::BTN_BRIGHT)) begin
            upd.bright  = (bright >= bright_top) ? '0 : bright + 1'b1;
            upd.changed = 1'b1;
        end
        return upd;
    endfunction

    // Predict on every accepted sample beat, check every accepted result beat.
    // Prediction runs first so a result beat taken together with its own sample beat would still find its entry.
    always @(posedge i_clk) begin : scoreboard_p
        t_panel_update got;
        t_panel_update want;
        int b;
        if (!i_rst_n) begin
            window_ms  = bdad_pkg::WINDOW_RESET;
            long_len   = bdad_pkg::LONG_PRESET_RESET;
            short_len  = bdad_pkg::SHORT_PRESET_RESET;
            bright_top = bdad_pkg::BRIGHT_TOP_RESET;
            held_level = '1;
            for (b = 0; b < MASK_W; b++) press_stamp[b] = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bdad_pkg::CFG_DEBOUNCE_WINDOW: window_ms  = i_cfg_data[WINDOW_W-1:0];
                    bdad_pkg::CFG_LONG_PRESET:     long_len   = i_cfg_data[LEN_W-1:0];
                    bdad_pkg::CFG_SHORT_PRESET:    short_len  = i_cfg_data[LEN_W-1:0];
                    bdad_pkg::CFG_BRIGHTNESS_TOP:  bright_top = i_cfg_data[BRIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall)
                expected_updates.push_back(decode_panel_sample(i_button_levels, i_now_ms,
                    i_timer_length_in, i_brightness_in, i_timer_running));
            if (o_out_valid && !i_out_stall) begin
                got.pressed = o_pressed_mask;
                got.multi   = o_multi_press;
                got.len     = o_timer_length_out;
                got.bright  = o_brightness_out;
                got.changed = o_brightness_changed;
                if (expected_updates.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", got, 0);
                end else begin
                    want = expected_updates.pop_front();
                    if (got.pressed !== want.pressed)
                        report_mismatch("pressed_mask", got.pressed, want.pressed);
                    if (got.multi !== want.multi)
                        report_mismatch("multi_press", got.multi, want.multi);
                    if (got.len !== want.len)
                        report_mismatch("timer_length_out", got.len, want.len);
                    if (got.bright !== want.bright)
                        report_mismatch("brightness_out", got.bright, want.bright);
                    if (got.changed !== want.changed)
                        report_mismatch("brightness_changed", got.changed, want.changed);
                end
            end
        end
    end

    // Receiver back-pressure: stall at random in the share that the phase asks for
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Send one sample beat; drop valid for random gaps first, then hold the
    // payload until the block takes it
    task automatic send_sample(logic [MASK_W-1:0] levels, logic [31:0] now,
        logic [LEN_W-1:0] len, logic [BRIGHT_W-1:0] bright, logic running);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_button_levels   <= levels;
        i_now_ms          <= now;
        i_timer_length_in <= len;
        i_brightness_in   <= bright;
        i_timer_running   <= running;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every outstanding result beat has come back
    task automatic drain_results();
        int spins;
        spins = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            spins++;
        end while (expected_updates.size() != 0 && spins < DRAIN_LIMIT);
        if (expected_updates.size() != 0) begin
            report_mismatch("result beats never arrived", expected_updates.size(), 0);
            expected_updates.delete();
        end
        // Let the block settle before touching registers
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back while the block is idle
    task automatic set_registers(logic [CFG_DATA_W-1:0] window, logic [CFG_DATA_W-1:0] long_p,
        logic [CFG_DATA_W-1:0] short_p, logic [CFG_DATA_W-1:0] top);
        logic [CFG_DATA_W-1:0] value [4];
        int k;
        value[bdad_pkg::CFG_DEBOUNCE_WINDOW] = window;
        value[bdad_pkg::CFG_LONG_PRESET]     = long_p;
        value[bdad_pkg::CFG_SHORT_PRESET]    = short_p;
        value[bdad_pkg::CFG_BRIGHTNESS_TOP]  = top;
        for (k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_INDEX_W'(k);
            i_cfg_data  <= value[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Press lockout straight after reset: press times start at zero
    task automatic test_reset_lockout();
        send_sample(press_of(bdad_pkg::BTN_LONG), 32'd100, 10'd7, 2'd0, 1'b0);   // too early
        send_sample(RELEASED,                     32'd0,   10'd7, 2'd0, 1'b0);
        send_sample(press_of(bdad_pkg::BTN_LONG), 32'd200, 10'd7, 2'd0, 1'b0);   // long preset
    endtask

    // Each button on its own, presets blocked while running, saturation, wrap
    task automatic test_button_actions();
        send_sample(RELEASED, 32'd1000, 10'd33, 2'd0, 1'b1);
        send_sample(press_of(bdad_pkg::BTN_SHORT), 32'd1000, 10'd33, 2'd0, 1'b1); // no load
        send_sample(RELEASED, 32'd1300, 10'd33, 2'd0, 1'b0);
        send_sample(press_of(bdad_pkg::BTN_SHORT), 32'd1300, 10'd33, 2'd0, 1'b0);
        send_sample(press_of(bdad_pkg::BTN_INC), 32'd1400, bdad_pkg::LEN_MAX, 2'd0, 1'b0);
        send_sample(RELEASED, 32'd1400, 10'd0, 2'd0, 1'b0);
        send_sample(press_of(bdad_pkg::BTN_INC), 32'd1700, 10'd0, 2'd0, 1'b0);
        send_sample(press_of(bdad_pkg::BTN_BRIGHT), 32'd1800, 10'd0, 2'd1, 1'b0);
        send_sample(RELEASED, 32'd1800, 10'd0, 2'd2, 1'b0);
        send_sample(press_of(bdad_pkg::BTN_BRIGHT), 32'd2100, 10'd0, 2'd2, 1'b0); // wrap
        send_sample(press_of(bdad_pkg::BTN_LONG), 32'd2200, 10'd500, 2'd3, 1'b1);
    endtask

    // Several buttons at once: no action, but the lockout still advances
    task automatic test_multi_press();
        logic [MASK_W-1:0] both;
        both = press_of(bdad_pkg::BTN_LONG) & press_of(bdad_pkg::BTN_SHORT);
        send_sample(RELEASED, 32'd3000, 10'd44, 2'd1, 1'b0);
        send_sample('0,       32'd3000, 10'd44, 2'd1, 1'b0);
        send_sample(RELEASED, 32'd3100, 10'd44, 2'd1, 1'b0);
        send_sample(both,     32'd3100, 10'd44, 2'd1, 1'b0);
        send_sample(RELEASED, 32'd3300, 10'd44, 2'd1, 1'b0);
        send_sample(both,     32'd3300, 10'd44, 2'd1, 1'b0);
    endtask

    // Elapsed time across the 2^32 wrap, including a press exactly one window late
    task automatic test_time_wrap();
        send_sample(RELEASED,                     32'hFFFF_FFFF, 10'd9, 2'd0, 1'b0);
        send_sample(press_of(bdad_pkg::BTN_LONG), 32'hFFFF_FFF0, 10'd9, 2'd0, 1'b0);
        send_sample(RELEASED,                     32'h0000_0050, 10'd9, 2'd0, 1'b0);
        send_sample(press_of(bdad_pkg::BTN_LONG), 32'h0000_0050, 10'd9, 2'd0, 1'b0);
        send_sample(RELEASED,                     32'h0000_00B8, 10'd9, 2'd0, 1'b0);
        send_sample(press_of(bdad_pkg::BTN_LONG), 32'h0000_00B8, 10'd9, 2'd0, 1'b0);
    endtask

    // Random samples: mostly clean presses and releases with a clock that
    // steps around the lockout window, plus some noise and large jumps
    task automatic run_random_phase(int count, int send_idle, int recv_idle);
        logic [31:0]         clock_ms;
        logic [MASK_W-1:0]   levels;
        logic [LEN_W-1:0]    len;
        int                  n;
        int                  r;
        int                  w;
        gap_pct   = send_idle;
        stall_pct = recv_idle;
        clock_ms  = $urandom;
        for (n = 0; n < count; n++) begin
            w = int'(window_ms);
            r = $urandom_range(99);
            if (r < 45)
                clock_ms += $urandom_range(w / 4 + 1);
            else if (r < 90)
                clock_ms += $urandom_range(w / 2, w + w / 2 + 1);
            else
                clock_ms += $urandom;
            r = $urandom_range(99);
            if (r < 45)
                levels = RELEASED;
            else if (r < 80)
                levels = press_of($urandom_range(MASK_W - 1));
            else if (r < 90)
                levels = press_of($urandom_range(MASK_W - 1))
                       & press_of($urandom_range(MASK_W - 1));
            else
                levels = MASK_W'($urandom);
            r = $urandom_range(99);
            if (r < 15)
                len = bdad_pkg::LEN_MAX;
            else if (r < 30)
                len = LEN_W'($urandom_range(3));
            else
                len = LEN_W'($urandom_range(int'(bdad_pkg::LEN_MAX)));
            send_sample(levels, clock_ms, len, BRIGHT_W'($urandom_range(3)),
                        $urandom_range(99) < 30);
        end
        drain_results();
    endtask

    initial begin
        gap_pct   = 28;
        stall_pct = 49;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed checks run on the reset register values
        test_reset_lockout();
        test_button_actions();
        test_multi_press();
        test_time_wrap();
        drain_results();

        // Mid-range settings; garbage above the narrow fields must be dropped
        set_registers(CFG_DATA_W'($urandom_range(50, 400)),
                      {6'($urandom), 10'($urandom)}, {6'($urandom), 10'($urandom)},
                      {14'($urandom), 2'($urandom)});
        run_random_phase(PHASE_ITEMS, 28, 49);

        // No lockout, zero presets on one side, brightness always wraps
        set_registers('0, {6'h3F, 10'd0}, {6'h00, bdad_pkg::LEN_MAX}, {14'h3FFF, 2'd0});
        run_random_phase(PHASE_ITEMS, 49, 28);

        // Longest lockout and top brightness, no idling either side
        set_registers('1, {6'h15, bdad_pkg::LEN_MAX}, {6'h2A, 10'd0}, {14'h0000, 2'd3});
        run_random_phase(PHASE_ITEMS, 0, 0);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard: far beyond the slowest correct run
    initial begin
        #(2 * CLK_HALF * 400_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
